// File: design/tdpf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpf_pkg
// Shared constants, status codes and word types of the toroidal disc
// packing filter.
// ----------------------------------------------------------------------------
package tdpf_pkg;

  localparam int STORE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

  localparam int COORD_W   = 16;
  localparam int RAD_W     = 15;
  localparam int GAP_W     = 17;
  localparam int SUM_W     = 18;
  localparam int DIST_W    = 15;
  localparam int MOD_STEPS = COORD_W;
  localparam int DIV_W     = COORD_W + MOD_STEPS - 1;

  // front stage, modulo cells, fold, square, compare
  localparam int CHAIN_STAGES = MOD_STEPS + 4;
  localparam int DRAIN_LAST   = CHAIN_STAGES + 1;
  localparam int DRAIN_W      = $clog2(DRAIN_LAST + 1);

  localparam logic [2:0] ST_PLACED      = 3'd0;
  localparam logic [2:0] ST_COLLIDED    = 3'd1;
  localparam logic [2:0] ST_NEG_RADIUS  = 3'd2;
  localparam logic [2:0] ST_OUT_OF_AREA = 3'd3;
  localparam logic [2:0] ST_FULL        = 3'd4;
  localparam logic [2:0] ST_CLEARED     = 3'd5;

  localparam logic [1:0] REG_AREA_WIDTH  = 2'd0;
  localparam logic [1:0] REG_AREA_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MIN_GAP     = 2'd2;

  localparam logic MODE_PLACE = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [15:0]        cand_x;
    logic [15:0]        cand_y;
    logic signed [15:0] cand_radius;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [10:0] dot_count;
    logic [9:0]  slot;
  } out_word_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [RAD_W-1:0]   r;
  } disc_t;

  typedef struct packed {
    logic [COORD_W-1:0]      area_w;
    logic [COORD_W-1:0]      area_h;
    logic signed [GAP_W-1:0] min_gap;
    logic [COORD_W-1:0]      cand_x;
    logic [COORD_W-1:0]      cand_y;
    logic [RAD_W-1:0]        cand_r;
  } scan_ctx_t;

  typedef struct packed {
    logic                    valid;
    logic [COORD_W-1:0]      rem_x;
    logic [COORD_W-1:0]      rem_y;
    logic [DIV_W-1:0]        div_x;
    logic [DIV_W-1:0]        div_y;
    logic signed [SUM_W-1:0] sum;
  } cell_t;

endpackage

// File: design/tdpf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpf_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tdpf_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/tdpf_mod_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpf_mod_cell
// One restoring-remainder step on the x and y lanes; hands the halved
// divisor to the next cell.
// ----------------------------------------------------------------------------
module tdpf_mod_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  tdpf_pkg::cell_t cell_in,
  output tdpf_pkg::cell_t cell_out
);

  tdpf_pkg::cell_t out_r;
  tdpf_pkg::cell_t out_nxt;

  always_comb begin
    out_nxt       = cell_in;
    out_nxt.div_x = cell_in.div_x >> 1;
    out_nxt.div_y = cell_in.div_y >> 1;
    if ({{(tdpf_pkg::DIV_W-tdpf_pkg::COORD_W){1'b0}}, cell_in.rem_x} >= cell_in.div_x) begin
      out_nxt.rem_x = cell_in.rem_x - cell_in.div_x[tdpf_pkg::COORD_W-1:0];
    end
    if ({{(tdpf_pkg::DIV_W-tdpf_pkg::COORD_W){1'b0}}, cell_in.rem_y} >= cell_in.div_y) begin
      out_nxt.rem_y = cell_in.rem_y - cell_in.div_y[tdpf_pkg::COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid <= 1'b0;
    end else begin
      out_r.valid <= out_nxt.valid;
    end
    out_r.rem_x <= out_nxt.rem_x;
    out_r.rem_y <= out_nxt.rem_y;
    out_r.div_x <= out_nxt.div_x;
    out_r.div_y <= out_nxt.div_y;
    out_r.sum   <= out_nxt.sum;
  end

  assign cell_out = out_r;

endmodule

// File: design/tdpf_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpf_chain
// Collision test pipeline: difference and radii sum, a chain of modulo
// cells, torus fold, squares and the final compare.
// ----------------------------------------------------------------------------
module tdpf_chain (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                disc_valid,
  input  tdpf_pkg::disc_t     disc,
  input  tdpf_pkg::scan_ctx_t ctx,
  output logic                hit
);

  tdpf_pkg::cell_t link [tdpf_pkg::MOD_STEPS+1];
  tdpf_pkg::cell_t front_r;
  tdpf_pkg::cell_t front_nxt;

  logic [tdpf_pkg::DIST_W-1:0] dx_r, dy_r;
  logic [tdpf_pkg::DIST_W-1:0] dx_nxt, dy_nxt;
  logic [tdpf_pkg::GAP_W-1:0]  smag_r, smag_nxt;
  logic                        fold_valid_r, spos_r, spos_nxt;

  logic [2*tdpf_pkg::DIST_W-1:0] dxx_r, dyy_r;
  logic [2*tdpf_pkg::GAP_W-1:0]  ss_r;
  logic                          sq_valid_r, sq_spos_r;

  logic [2*tdpf_pkg::GAP_W-1:0] dist_sq;
  logic                         hit_r;

  always_comb begin
    front_nxt.valid = disc_valid;
    front_nxt.rem_x = (ctx.cand_x >= disc.x) ? ctx.cand_x - disc.x : disc.x - ctx.cand_x;
    front_nxt.rem_y = (ctx.cand_y >= disc.y) ? ctx.cand_y - disc.y : disc.y - ctx.cand_y;
    front_nxt.div_x = {ctx.area_w, {(tdpf_pkg::MOD_STEPS-1){1'b0}}};
    front_nxt.div_y = {ctx.area_h, {(tdpf_pkg::MOD_STEPS-1){1'b0}}};
    front_nxt.sum   = $signed({3'b000, ctx.cand_r}) + $signed({3'b000, disc.r})
                    + $signed({ctx.min_gap[tdpf_pkg::GAP_W-1], ctx.min_gap});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r.valid <= 1'b0;
    end else begin
      front_r.valid <= front_nxt.valid;
    end
    front_r.rem_x <= front_nxt.rem_x;
    front_r.rem_y <= front_nxt.rem_y;
    front_r.div_x <= front_nxt.div_x;
    front_r.div_y <= front_nxt.div_y;
    front_r.sum   <= front_nxt.sum;
  end

  assign link[0] = front_r;

  for (genvar g = 0; g < tdpf_pkg::MOD_STEPS; g++) begin : g_cell
    tdpf_mod_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_in  (link[g]),
      .cell_out (link[g+1])
    );
  end

  // fold onto the shorter way around the ring
  always_comb begin
    tdpf_pkg::cell_t last;
    last = link[tdpf_pkg::MOD_STEPS];
    if ({last.rem_x, 1'b0} > {1'b0, ctx.area_w}) begin
      dx_nxt = tdpf_pkg::DIST_W'(ctx.area_w - last.rem_x);
    end else begin
      dx_nxt = tdpf_pkg::DIST_W'(last.rem_x);
    end
    if ({last.rem_y, 1'b0} > {1'b0, ctx.area_h}) begin
      dy_nxt = tdpf_pkg::DIST_W'(ctx.area_h - last.rem_y);
    end else begin
      dy_nxt = tdpf_pkg::DIST_W'(last.rem_y);
    end
    spos_nxt = !last.sum[tdpf_pkg::SUM_W-1] && (last.sum != '0);
    smag_nxt = spos_nxt ? last.sum[tdpf_pkg::GAP_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fold_valid_r <= 1'b0;
      sq_valid_r   <= 1'b0;
      hit_r        <= 1'b0;
    end else begin
      fold_valid_r <= link[tdpf_pkg::MOD_STEPS].valid;
      sq_valid_r   <= fold_valid_r;
      hit_r        <= sq_valid_r && sq_spos_r && (dist_sq < ss_r);
    end
    dx_r      <= dx_nxt;
    dy_r      <= dy_nxt;
    smag_r    <= smag_nxt;
    spos_r    <= spos_nxt;
    dxx_r     <= dx_r * dx_r;
    dyy_r     <= dy_r * dy_r;
    ss_r      <= smag_r * smag_r;
    sq_spos_r <= spos_r;
  end

  assign dist_sq = (2*tdpf_pkg::GAP_W)'(dxx_r) + (2*tdpf_pkg::GAP_W)'(dyy_r);
  assign hit     = hit_r;

endmodule

// File: design/toroidal_disc_packing_filter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toroidal_disc_packing_filter_unit
// Dart-throwing disc packer on a torus: checks each candidate against all
// stored discs with wrapped distance and appends it when clean and the store is not full.
// ----------------------------------------------------------------------------
//  channel  ports                           word
//  input    in_valid  in_stall  in_word     mode, cand_x, cand_y, cand_radius
//  output   out_valid out_stall out_word    status, dot_count, slot
//  config   cfg_we  cfg_index  cfg_data     area_width, area_height, min_gap
//
//  A candidate tested against N >= 1 stored discs is scanned first: the
//  disc RAM gives one stored disc per cycle into a 20-stage compare chain,
//  which is then drained. A candidate on an empty store skips the scan.
//  Clear and rejected words go straight to the response state.
//  Reset empties the store at once; RAM contents need no clearing.
//  A finished word waits in the output register while out_stall is high.
// ----------------------------------------------------------------------------
module toroidal_disc_packing_filter_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tdpf_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output tdpf_pkg::out_word_t out_word,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [16:0]         cfg_data
);

  typedef enum logic [2:0] {IDLE, SCAN, DRAIN, DECIDE, RESP} state_t;

  state_t state_r, state_nxt;

  logic [tdpf_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [tdpf_pkg::CNT_W-1:0]   idx_r, idx_nxt;
  logic [tdpf_pkg::DRAIN_W-1:0] drain_r, drain_nxt;
  logic                         hit_r, hit_nxt;
  logic                         rd_valid_r;
  logic                         out_valid_r, out_valid_nxt;

  logic [15:0]                  area_w_r, area_w_nxt;
  logic [15:0]                  area_h_r, area_h_nxt;
  logic signed [16:0]           gap_r, gap_nxt;
  logic [15:0]                  cand_x_r, cand_x_nxt;
  logic [15:0]                  cand_y_r, cand_y_nxt;
  logic [tdpf_pkg::RAD_W-1:0]   cand_r_r, cand_r_nxt;
  tdpf_pkg::out_word_t          res_r, res_nxt;
  tdpf_pkg::out_word_t          out_word_r, out_word_nxt;

  logic                         accept, issue, wr_en, chain_hit;
  tdpf_pkg::disc_t              wr_disc, rd_disc;
  logic [$bits(tdpf_pkg::disc_t)-1:0] rd_data;
  tdpf_pkg::scan_ctx_t          ctx;

  assign in_stall = (state_r != IDLE);
  assign accept   = in_valid && (state_r == IDLE);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    drain_nxt     = drain_r;
    hit_nxt       = hit_r || chain_hit;
    out_valid_nxt = out_valid_r && out_stall;
    area_w_nxt    = area_w_r;
    area_h_nxt    = area_h_r;
    gap_nxt       = gap_r;
    cand_x_nxt    = cand_x_r;
    cand_y_nxt    = cand_y_r;
    cand_r_nxt    = cand_r_r;
    res_nxt       = res_r;
    out_word_nxt  = out_word_r;
    issue         = 1'b0;
    wr_en         = 1'b0;

    if (cfg_we) begin
      case (cfg_index)
        tdpf_pkg::REG_AREA_WIDTH:  area_w_nxt = cfg_data[15:0];
        tdpf_pkg::REG_AREA_HEIGHT: area_h_nxt = cfg_data[15:0];
        tdpf_pkg::REG_MIN_GAP:     gap_nxt    = cfg_data;
        default: ;
      endcase
    end

    case (state_r)
      IDLE: begin
        if (accept) begin
          hit_nxt         = 1'b0;
          idx_nxt         = '0;
          cand_x_nxt      = in_word.cand_x;
          cand_y_nxt      = in_word.cand_y;
          cand_r_nxt      = in_word.cand_radius[tdpf_pkg::RAD_W-1:0];
          res_nxt.slot      = '0;
          res_nxt.dot_count = 11'(count_r);
          if (in_word.mode == tdpf_pkg::MODE_CLEAR) begin
            count_nxt         = '0;
            res_nxt.dot_count = '0;
            res_nxt.status    = tdpf_pkg::ST_CLEARED;
            state_nxt         = RESP;
          end else if (in_word.cand_radius[15]) begin
            res_nxt.status = tdpf_pkg::ST_NEG_RADIUS;
            state_nxt      = RESP;
          end else if (in_word.cand_x >= area_w_r || in_word.cand_y >= area_h_r) begin
            res_nxt.status = tdpf_pkg::ST_OUT_OF_AREA;
            state_nxt      = RESP;
          end else if (count_r == '0) begin
            state_nxt = DECIDE;
          end else begin
            state_nxt = SCAN;
          end
        end
      end
      SCAN: begin
        issue   = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == count_r - 1'b1) begin
          drain_nxt = '0;
          state_nxt = DRAIN;
        end
      end
      DRAIN: begin
        drain_nxt = drain_r + 1'b1;
        if (drain_r == tdpf_pkg::DRAIN_W'(tdpf_pkg::DRAIN_LAST)) begin
          state_nxt = DECIDE;
        end
      end
      DECIDE: begin
        res_nxt.slot      = '0;
        res_nxt.dot_count = 11'(count_r);
        if (hit_r) begin
          res_nxt.status = tdpf_pkg::ST_COLLIDED;
        end else if (count_r == tdpf_pkg::CNT_W'(tdpf_pkg::STORE_DEPTH)) begin
          res_nxt.status = tdpf_pkg::ST_FULL;
        end else begin
          wr_en             = 1'b1;
          count_nxt         = count_r + 1'b1;
          res_nxt.status    = tdpf_pkg::ST_PLACED;
          res_nxt.slot      = 10'(count_r);
          res_nxt.dot_count = 11'(count_r + 1'b1);
        end
        state_nxt = RESP;
      end
      RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_word_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = IDLE;
        end
      end
      default: state_nxt = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      drain_r     <= '0;
      hit_r       <= 1'b0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      area_w_r    <= 16'hFFFF;
      area_h_r    <= 16'hFFFF;
      gap_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      drain_r     <= drain_nxt;
      hit_r       <= hit_nxt;
      rd_valid_r  <= issue;
      out_valid_r <= out_valid_nxt;
      area_w_r    <= area_w_nxt;
      area_h_r    <= area_h_nxt;
      gap_r       <= gap_nxt;
    end
    cand_x_r   <= cand_x_nxt;
    cand_y_r   <= cand_y_nxt;
    cand_r_r   <= cand_r_nxt;
    res_r      <= res_nxt;
    out_word_r <= out_word_nxt;
  end

  assign wr_disc.x = cand_x_r;
  assign wr_disc.y = cand_y_r;
  assign wr_disc.r = cand_r_r;

  tdpf_ram #(
    .DATA_W ($bits(tdpf_pkg::disc_t)),
    .DEPTH  (tdpf_pkg::STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[tdpf_pkg::ADDR_W-1:0]),
    .wr_data (wr_disc),
    .rd_en   (issue),
    .rd_addr (idx_r[tdpf_pkg::ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  assign rd_disc = rd_data;

  assign ctx.area_w  = area_w_r;
  assign ctx.area_h  = area_h_r;
  assign ctx.min_gap = gap_r;
  assign ctx.cand_x  = cand_x_r;
  assign ctx.cand_y  = cand_y_r;
  assign ctx.cand_r  = cand_r_r;

  tdpf_chain u_chain (
    .clk        (clk),
    .rst_n      (rst_n),
    .disc_valid (rd_valid_r),
    .disc       (rd_disc),
    .ctx        (ctx),
    .hit        (chain_hit)
  );

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
